// ----- hdl/smpn_pkg.sv -----
// Shared types and constants for the SMP pairing feature negotiation block.
package smpn_pkg;

  // Configuration register indexes
  localparam logic CFG_AUTH_MASK    = 1'b0;
  localparam logic CFG_KEYDIST_MASK = 1'b1;

  // Reset values of the configuration registers
  localparam logic [7:0] AUTH_MASK_RST    = 8'h3F;
  localparam logic [7:0] KEYDIST_MASK_RST = 8'h0F;

  // Auth requirement bits
  localparam int unsigned AUTH_BOND_BIT = 0;
  localparam int unsigned AUTH_MITM_BIT = 2;
  localparam int unsigned AUTH_SC_BIT   = 3;
  localparam logic [1:0]  AUTH_BOND_MAX = 2'd1;

  // IO capability codes
  localparam logic [2:0] IO_DISP_ONLY = 3'd0;
  localparam logic [2:0] IO_YES_NO    = 3'd1;
  localparam logic [2:0] IO_KEYB_ONLY = 3'd2;
  localparam logic [2:0] IO_NONE      = 3'd3;
  localparam logic [2:0] IO_KEYB_DISP = 3'd4;

  // Limits on feature fields
  localparam logic [7:0] IO_CAP_MAX   = 8'd4;
  localparam logic [7:0] OOB_FLAG_MAX = 8'd1;
  localparam logic [7:0] KEY_MIN      = 8'd7;
  localparam logic [7:0] KEY_MAX      = 8'd16;

  // Association methods
  localparam logic [2:0] M_JUST_WORKS = 3'd0;
  localparam logic [2:0] M_NUMERIC    = 3'd1;
  localparam logic [2:0] M_PK_BOTH    = 3'd2;
  localparam logic [2:0] M_PK_RSP_DSP = 3'd3;
  localparam logic [2:0] M_PK_INI_DSP = 3'd4;
  localparam logic [2:0] M_OOB        = 3'd5;

  // Stage 1 payload: checks done, agreed flags and key size
  typedef struct packed {
    logic       err;
    logic       sc;
    logic       bond;
    logic       mitm;
    logic [4:0] key_size;
    logic [7:0] init_dist;
    logic [7:0] resp_dist;
    logic [2:0] ini_io;
    logic [2:0] rsp_io;
    logic       ini_oob;
    logic       rsp_oob;
  } s1_t;

  // Stage 2 payload: method chosen
  typedef struct packed {
    logic       err;
    logic       sc;
    logic       bond;
    logic       mitm;
    logic [4:0] key_size;
    logic [7:0] init_dist;
    logic [7:0] resp_dist;
    logic [2:0] method;
  } s2_t;

endpackage

// ----- hdl/smp_pairing_negotiation.sv -----
// Top level: SMP pairing feature validation and association method selection.
//
// Usage:
//   Input channel (in_valid/in_ready) carries the six feature bytes of a
//   pairing request and of the matching pairing response as one request.
//   Output channel (out_valid/out_ready) returns one result per request:
//   status, agreed SC/bonding/MITM flags, minimum key size, the response's
//   key distribution and the association method. On an invalid exchange
//   status is 1 and every other field is zero.
//   Configuration (cfg_we/cfg_index/cfg_wdata) writes the auth and key
//   distribution masks; write only while the block is empty.
// Timing:
//   Three register stages (checks, method select, output register), which
//   each request passes through in that order. One request is
//   taken every cycle while the output is drained.
// Reset and stall:
//   Synchronous active-low reset empties all stages and reloads the masks.
//   Each stage holds its request while the next one is full and stalled;
//   empty stages further up keep filling, so up to three requests are held
//   with out_ready low before in_ready drops.
module smp_pairing_negotiation
  import smpn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  // request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_req_io_cap,
  input  logic [7:0] in_req_oob_flag,
  input  logic [7:0] in_req_auth,
  input  logic [7:0] in_req_max_key,
  input  logic [7:0] in_req_init_dist,
  input  logic [7:0] in_req_resp_dist,
  input  logic [7:0] in_rsp_io_cap,
  input  logic [7:0] in_rsp_oob_flag,
  input  logic [7:0] in_rsp_auth,
  input  logic [7:0] in_rsp_max_key,
  input  logic [7:0] in_rsp_init_dist,
  input  logic [7:0] in_rsp_resp_dist,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_status,
  output logic       out_secure_conn,
  output logic       out_bonding,
  output logic       out_mitm,
  output logic [4:0] out_key_size,
  output logic [7:0] out_init_dist,
  output logic [7:0] out_resp_dist,
  output logic [2:0] out_method
);

  logic [7:0] auth_mask_r, auth_mask_nxt;
  logic [7:0] kd_mask_r, kd_mask_nxt;

  logic       v1_r, v2_r, v3_r;
  s1_t        s1_r, s1_nxt;
  s2_t        s2_r, s2_nxt;
  s2_t        s3_r, s3_nxt;
  logic       rdy2, rdy3;
  logic       req_ok, rsp_ok, dist_ok;

  // ---------------------------------------------------------------------
  // Configuration registers
  always_comb begin
    auth_mask_nxt = auth_mask_r;
    kd_mask_nxt   = kd_mask_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_AUTH_MASK:    auth_mask_nxt = cfg_wdata;
        CFG_KEYDIST_MASK: kd_mask_nxt   = cfg_wdata;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auth_mask_r <= AUTH_MASK_RST;
      kd_mask_r   <= KEYDIST_MASK_RST;
    end else begin
      auth_mask_r <= auth_mask_nxt;
      kd_mask_r   <= kd_mask_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Per-stage handshake: a stage loads when empty or when it drains
  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign in_ready = !v1_r || rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (in_ready) v1_r <= in_valid;
      if (rdy2)     v2_r <= v1_r;
      if (rdy3)     v3_r <= v2_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: feature set checks, agreed flags, smaller key size
  function automatic logic set_ok(input logic [7:0] io, input logic [7:0] oob,
                                  input logic [7:0] auth, input logic [7:0] mk,
                                  input logic [7:0] idist, input logic [7:0] rdist,
                                  input logic [7:0] amask, input logic [7:0] kmask);
    set_ok = (io <= IO_CAP_MAX) && (oob <= OOB_FLAG_MAX) &&
             ((auth & ~amask) == 8'd0) && (auth[1:0] <= AUTH_BOND_MAX) &&
             (mk >= KEY_MIN) && (mk <= KEY_MAX) &&
             ((idist & ~kmask) == 8'd0) && ((rdist & ~kmask) == 8'd0);
  endfunction

  always_comb begin
    req_ok  = set_ok(in_req_io_cap, in_req_oob_flag, in_req_auth, in_req_max_key,
                     in_req_init_dist, in_req_resp_dist, auth_mask_r, kd_mask_r);
    rsp_ok  = set_ok(in_rsp_io_cap, in_rsp_oob_flag, in_rsp_auth, in_rsp_max_key,
                     in_rsp_init_dist, in_rsp_resp_dist, auth_mask_r, kd_mask_r);
    // response may not add distribution bits
    dist_ok = ((in_rsp_init_dist & ~in_req_init_dist) == 8'd0) &&
              ((in_rsp_resp_dist & ~in_req_resp_dist) == 8'd0);

    s1_nxt.err       = !(req_ok && rsp_ok && dist_ok);
    s1_nxt.sc        = in_req_auth[AUTH_SC_BIT] & in_rsp_auth[AUTH_SC_BIT];
    s1_nxt.bond      = in_req_auth[AUTH_BOND_BIT] & in_rsp_auth[AUTH_BOND_BIT];
    s1_nxt.mitm      = in_req_auth[AUTH_MITM_BIT] | in_rsp_auth[AUTH_MITM_BIT];
    s1_nxt.key_size  = (in_req_max_key < in_rsp_max_key) ? in_req_max_key[4:0]
                                                         : in_rsp_max_key[4:0];
    s1_nxt.init_dist = in_rsp_init_dist;
    s1_nxt.resp_dist = in_rsp_resp_dist;
    // valid caps are at most 4, so three bits carry them
    s1_nxt.ini_io    = in_req_io_cap[2:0];
    s1_nxt.rsp_io    = in_rsp_io_cap[2:0];
    s1_nxt.ini_oob   = (in_req_oob_flag != 8'd0);
    s1_nxt.rsp_oob   = (in_rsp_oob_flag != 8'd0);
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_r <= s1_nxt;
  end

  // ---------------------------------------------------------------------
  // Stage 2: association method
  function automatic logic can_confirm(input logic [2:0] io);
    can_confirm = (io == IO_YES_NO) || (io == IO_KEYB_DISP);
  endfunction

  function automatic logic can_show(input logic [2:0] io);
    can_show = (io == IO_DISP_ONLY) || (io == IO_YES_NO) || (io == IO_KEYB_DISP);
  endfunction

  function automatic logic [2:0] pick_io_method(input logic [2:0] ini,
                                                input logic [2:0] rsp,
                                                input logic       sc);
    if (sc && can_confirm(ini) && can_confirm(rsp))
      pick_io_method = M_NUMERIC;
    else if (ini == IO_NONE || rsp == IO_NONE)
      pick_io_method = M_JUST_WORKS;
    else if (ini == IO_KEYB_ONLY && rsp == IO_KEYB_ONLY)
      pick_io_method = M_PK_BOTH;
    else if (ini == IO_KEYB_ONLY && can_show(rsp))
      pick_io_method = M_PK_RSP_DSP;
    else if (rsp == IO_KEYB_ONLY && can_show(ini))
      pick_io_method = M_PK_INI_DSP;
    else
      pick_io_method = M_JUST_WORKS;
  endfunction

  always_comb begin
    logic oob;
    // with SC one OOB flag is enough, otherwise both are needed
    oob = s1_r.sc ? (s1_r.ini_oob | s1_r.rsp_oob) : (s1_r.ini_oob & s1_r.rsp_oob);

    s2_nxt.err       = s1_r.err;
    s2_nxt.sc        = s1_r.sc;
    s2_nxt.bond      = s1_r.bond;
    s2_nxt.mitm      = s1_r.mitm;
    s2_nxt.key_size  = s1_r.key_size;
    s2_nxt.init_dist = s1_r.init_dist;
    s2_nxt.resp_dist = s1_r.resp_dist;
    if (oob)
      s2_nxt.method = M_OOB;
    else if (!s1_r.mitm)
      s2_nxt.method = M_JUST_WORKS;
    else
      s2_nxt.method = pick_io_method(s1_r.ini_io, s1_r.rsp_io, s1_r.sc);
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) s2_r <= s2_nxt;
  end

  // ---------------------------------------------------------------------
  // Stage 3: output register, fields cleared on error
  always_comb begin
    s3_nxt = s2_r;
    if (s2_r.err) begin
      s3_nxt     = '0;
      s3_nxt.err = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) s3_r <= s3_nxt;
  end

  assign out_valid       = v3_r;
  assign out_status      = s3_r.err;
  assign out_secure_conn = s3_r.sc;
  assign out_bonding     = s3_r.bond;
  assign out_mitm        = s3_r.mitm;
  assign out_key_size    = s3_r.key_size;
  assign out_init_dist   = s3_r.init_dist;
  assign out_resp_dist   = s3_r.resp_dist;
  assign out_method      = s3_r.method;

`ifndef ASSERT_OFF
  // error result carries no other information
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_key_size == 5'd0 && out_method == M_JUST_WORKS &&
      !out_secure_conn && !out_bonding && !out_mitm &&
      out_init_dist == 8'd0 && out_resp_dist == 8'd0)
    else $error("error result has non-zero fields");

  // agreed key size lies within the legal range
  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_status |-> out_key_size >= 5'd7 && out_key_size <= 5'd16)
    else $error("agreed key size out of range");

  // without MITM only just works or OOB can be chosen
  a_no_mitm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_status && !out_mitm |->
      out_method == M_JUST_WORKS || out_method == M_OOB)
    else $error("passkey or numeric method without MITM");

  // method code is always a defined one
  a_method_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_method <= M_OOB)
    else $error("undefined method code");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !v1_r && !v2_r)
    else $error("pipeline not empty after reset");
`endif

endmodule

// ----- sim/tb_smp_pairing_negotiation.sv -----
// Self-checking testbench for the SMP pairing feature negotiation block.
`timescale 1ns / 1ps

module tb_smp_pairing_negotiation;
  import smpn_pkg::*;

  // One side of the exchange: the six feature bytes
  typedef struct packed {
    logic [7:0] io_cap;
    logic [7:0] oob_flag;
    logic [7:0] auth;
    logic [7:0] max_key;
    logic [7:0] init_dist;
    logic [7:0] resp_dist;
  } side_t;

  typedef struct packed {
    side_t req;
    side_t rsp;
  } exchange_t;

  typedef struct packed {
    logic       status;
    logic       secure_conn;
    logic       bonding;
    logic       mitm;
    logic [4:0] key_size;
    logic [7:0] init_dist;
    logic [7:0] resp_dist;
    logic [2:0] method;
  } outcome_t;

  // Directed row: request, whether the outcome is pinned, pinned outcome
  typedef struct packed {
    exchange_t xchg;
    logic      pinned;
    outcome_t  want;
  } dir_row_t;

  typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  localparam logic [28:0] BY_MODEL  = 29'd0;
  localparam logic [28:0] REJECTED  = {1'b1, 1'b1, 27'd0};
  localparam int          LONG_HOLD = 80;
  localparam int          NUM_PHASES = 7;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_index = CFG_AUTH_MASK;
  logic [7:0] cfg_wdata = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  exchange_t  in_xchg = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_status;
  logic       out_secure_conn;
  logic       out_bonding;
  logic       out_mitm;
  logic [4:0] out_key_size;
  logic [7:0] out_init_dist;
  logic [7:0] out_resp_dist;
  logic [2:0] out_method;

  // Local copy of the mask registers
  logic [7:0] tb_auth_mask = AUTH_MASK_RST;
  logic [7:0] tb_dist_mask = KEYDIST_MASK_RST;

  outcome_t   agreed_q[$];
  dir_row_t   directed_rows[$];
  int         fail_count = 0;
  logic       long_hold_req = 1'b0;

  logic [7:0] auth_plan [NUM_PHASES] = '{8'hFF, 8'h00, 8'h0D, 8'h3F, 8'h3F, 8'hF0, 8'h05};
  logic [7:0] dist_plan [NUM_PHASES] = '{8'hFF, 8'h00, 8'h07, 8'h0F, 8'h0F, 8'h0F, 8'hFF};

  smp_pairing_negotiation u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_io_cap    (in_xchg.req.io_cap),
    .in_req_oob_flag  (in_xchg.req.oob_flag),
    .in_req_auth      (in_xchg.req.auth),
    .in_req_max_key   (in_xchg.req.max_key),
    .in_req_init_dist (in_xchg.req.init_dist),
    .in_req_resp_dist (in_xchg.req.resp_dist),
    .in_rsp_io_cap    (in_xchg.rsp.io_cap),
    .in_rsp_oob_flag  (in_xchg.rsp.oob_flag),
    .in_rsp_auth      (in_xchg.rsp.auth),
    .in_rsp_max_key   (in_xchg.rsp.max_key),
    .in_rsp_init_dist (in_xchg.rsp.init_dist),
    .in_rsp_resp_dist (in_xchg.rsp.resp_dist),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_secure_conn  (out_secure_conn),
    .out_bonding      (out_bonding),
    .out_mitm         (out_mitm),
    .out_key_size     (out_key_size),
    .out_init_dist    (out_init_dist),
    .out_resp_dist    (out_resp_dist),
    .out_method       (out_method)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Feature set sanity against the current masks
  function automatic logic side_ok(side_t s);
    return s.io_cap <= IO_CAP_MAX && s.oob_flag <= OOB_FLAG_MAX &&
           (s.auth & ~tb_auth_mask) == 0 && s.auth[1:0] <= AUTH_BOND_MAX &&
           s.max_key >= KEY_MIN && s.max_key <= KEY_MAX &&
           (s.init_dist & ~tb_dist_mask) == 0 && (s.resp_dist & ~tb_dist_mask) == 0;
  endfunction

  // Association method from the two IO capabilities once MITM is wanted
  function automatic logic [2:0] choose_method(logic [2:0] ini, logic [2:0] rsp, logic sc);
    logic ini_conf, rsp_conf, ini_show, rsp_show;
    ini_conf = (ini == IO_YES_NO) || (ini == IO_KEYB_DISP);
    rsp_conf = (rsp == IO_YES_NO) || (rsp == IO_KEYB_DISP);
    ini_show = ini_conf || (ini == IO_DISP_ONLY);
    rsp_show = rsp_conf || (rsp == IO_DISP_ONLY);
    if (sc && ini_conf && rsp_conf) return M_NUMERIC;
    if (ini == IO_NONE || rsp == IO_NONE) return M_JUST_WORKS;
    if (ini == IO_KEYB_ONLY && rsp == IO_KEYB_ONLY) return M_PK_BOTH;
    if (ini == IO_KEYB_ONLY && rsp_show) return M_PK_RSP_DSP;
    if (rsp == IO_KEYB_ONLY && ini_show) return M_PK_INI_DSP;
    return M_JUST_WORKS;
  endfunction

  // Agreed pairing parameters for one exchange
  function automatic outcome_t negotiate(exchange_t x);
    outcome_t r;
    logic     sc, oob;
    r = '0;
    if (!side_ok(x.req) || !side_ok(x.rsp) ||
        (x.rsp.init_dist & ~x.req.init_dist) != 0 ||
        (x.rsp.resp_dist & ~x.req.resp_dist) != 0) begin
      r.status = 1'b1;
      return r;
    end
    sc = x.req.auth[AUTH_SC_BIT] & x.rsp.auth[AUTH_SC_BIT];
    r.secure_conn = sc;
    r.bonding = x.req.auth[AUTH_BOND_BIT] & x.rsp.auth[AUTH_BOND_BIT];
    r.mitm = x.req.auth[AUTH_MITM_BIT] | x.rsp.auth[AUTH_MITM_BIT];
    r.key_size = (x.req.max_key < x.rsp.max_key) ? x.req.max_key[4:0] : x.rsp.max_key[4:0];
    r.init_dist = x.rsp.init_dist;
    r.resp_dist = x.rsp.resp_dist;
    // with SC one side's OOB data is enough, legacy pairing needs both
    if (sc) oob = (x.req.oob_flag != 0) || (x.rsp.oob_flag != 0);
    else oob = (x.req.oob_flag != 0) && (x.rsp.oob_flag != 0);
    if (oob) r.method = M_OOB;
    else if (!r.mitm) r.method = M_JUST_WORKS;
    else r.method = choose_method(x.req.io_cap[2:0], x.rsp.io_cap[2:0], sc);
    return r;
  endfunction

  // Well-formed side; distribution bits limited by the given masks
  function automatic side_t gen_side(logic [7:0] ilim, logic [7:0] rlim);
    side_t s;
    s.io_cap    = 8'($urandom_range(0, 4));
    s.oob_flag  = 8'($urandom_range(0, 1));
    s.auth      = 8'($urandom) & tb_auth_mask & 8'hFD;
    s.max_key   = 8'($urandom_range(KEY_MIN, KEY_MAX));
    s.init_dist = 8'($urandom) & ilim;
    s.resp_dist = 8'($urandom) & rlim;
    return s;
  endfunction

  // Mostly valid exchanges, then single-byte corruption and pure noise
  function automatic exchange_t gen_exchange();
    exchange_t x;
    int        k, roll;
    x.req = gen_side(tb_dist_mask, tb_dist_mask);
    x.rsp = gen_side(x.req.init_dist, x.req.resp_dist);
    roll = $urandom_range(0, 99);
    if (roll >= 90) begin
      x = {$urandom, $urandom, $urandom};
    end else if (roll >= 70) begin
      k = $urandom_range(0, 11);
      x[k*8 +: 8] = 8'($urandom_range(0, 255));
    end
    return x;
  endfunction

  // Offer one request, hold it until taken, then log its expected outcome
  task automatic send_request(exchange_t x, outcome_t want);
    @(negedge clk);
    in_valid <= 1'b1;
    in_xchg  <= x;
    do @(posedge clk); while (!in_ready);
    agreed_q.push_back(want);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Stop offering and let every outstanding result come back
  task automatic finish_outstanding();
    @(negedge clk);
    in_valid <= 1'b0;
    while (agreed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mask(logic idx, logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_AUTH_MASK) tb_auth_mask = val;
    else tb_dist_mask = val;
  endtask

  // Random requests in bursts of random length with random gaps
  task automatic run_traffic(int n);
    exchange_t x;
    int        sent;
    sent = 0;
    while (sent < n) begin
      repeat ($urandom_range(1, 30)) begin
        if (sent < n) begin
          x = gen_exchange();
          send_request(x, negotiate(x));
          sent++;
        end
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
    end
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Result side: stall pattern switches mode now and then; long hold on demand
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left, hold_left, tick;
    mode = RX_FREE;
    mode_left = 0;
    hold_left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      tick++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          RX_FREE:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: out_ready <= (tick % 4 == 0);
          default:   out_ready <= ($urandom_range(0, 6) != 0);
        endcase
      end
    end
  end

  // Compare each result with the oldest outstanding expectation
  always @(posedge clk) begin : monitor
    outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      if (agreed_q.size() == 0) begin
        $display("%0t: result with nothing outstanding, expected none, got status %0d",
                 $time, out_status);
        fail_count++;
      end else begin
        want = agreed_q.pop_front();
        check_field("status", want.status, out_status);
        check_field("secure_conn", want.secure_conn, out_secure_conn);
        check_field("bonding", want.bonding, out_bonding);
        check_field("mitm", want.mitm, out_mitm);
        check_field("key_size", want.key_size, out_key_size);
        check_field("init_dist", want.init_dist, out_init_dist);
        check_field("resp_dist", want.resp_dist, out_resp_dist);
        check_field("method", want.method, out_method);
      end
    end
  end

  initial begin : stimulus
    dir_row_t row;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows: req bytes, rsp bytes (io, oob, auth, max key, init, resp)
    // baseline, nothing asked for: just works, full key size
    directed_rows.push_back({8'd3, 8'd0, 8'h00, 8'd16, 8'h0F, 8'h0F,
                             8'd3, 8'd0, 8'h00, 8'd16, 8'h0F, 8'h0F,
                             1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 5'd16, 8'h0F, 8'h0F, M_JUST_WORKS});
    // everything on, smallest key: numeric comparison
    directed_rows.push_back({8'd1, 8'd0, 8'h0D, 8'd16, 8'h0F, 8'h0F,
                             8'd1, 8'd0, 8'h0D, 8'd7,  8'h00, 8'h00,
                             1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 5'd7, 8'h00, 8'h00, M_NUMERIC});
    // field range violations
    directed_rows.push_back({8'd5, 8'd0, 8'h00, 8'd16, 8'h0F, 8'h0F,
                             8'd3, 8'd0, 8'h00, 8'd16, 8'h0F, 8'h0F, REJECTED});
    directed_rows.push_back({8'd3, 8'd0, 8'h00, 8'd16, 8'h0F, 8'h0F,
                             8'd255, 8'd0, 8'h00, 8'd16, 8'h0F, 8'h0F, REJECTED});
    directed_rows.push_back({8'd3, 8'd2, 8'h00, 8'd16, 8'h0F, 8'h0F,
                             8'd3, 8'd0, 8'h00, 8'd16, 8'h0F, 8'h0F, REJECTED});
    directed_rows.push_back({8'd3, 8'd0, 8'h00, 8'd16, 8'h0F, 8'h0F,
                             8'd3, 8'd255, 8'h00, 8'd16, 8'h0F, 8'h0F, REJECTED});
    directed_rows.push_back({8'd3, 8'd0, 8'h40, 8'd16, 8'h0F, 8'h0F,
                             8'd3, 8'd0, 8'h00, 8'd16, 8'h0F, 8'h0F, REJECTED});
    directed_rows.push_back({8'd3, 8'd0, 8'h00, 8'd16, 8'h0F, 8'h0F,
                             8'd3, 8'd0, 8'h02, 8'd16, 8'h0F, 8'h0F, REJECTED});
    directed_rows.push_back({8'd3, 8'd0, 8'h03, 8'd16, 8'h0F, 8'h0F,
                             8'd3, 8'd0, 8'h00, 8'd16, 8'h0F, 8'h0F, REJECTED});
    directed_rows.push_back({8'd3, 8'd0, 8'h00, 8'd6,  8'h0F, 8'h0F,
                             8'd3, 8'd0, 8'h00, 8'd16, 8'h0F, 8'h0F, REJECTED});
    directed_rows.push_back({8'd3, 8'd0, 8'h00, 8'd16, 8'h0F, 8'h0F,
                             8'd3, 8'd0, 8'h00, 8'd17, 8'h0F, 8'h0F, REJECTED});
    directed_rows.push_back({8'd3, 8'd0, 8'h00, 8'd16, 8'h10, 8'h0F,
                             8'd3, 8'd0, 8'h00, 8'd16, 8'h00, 8'h0F, REJECTED});
    directed_rows.push_back({8'd3, 8'd0, 8'h00, 8'd16, 8'h0F, 8'h0F,
                             8'd3, 8'd0, 8'h00, 8'd16, 8'h0F, 8'h80, REJECTED});
    // response adds distribution bits the request lacked
    directed_rows.push_back({8'd3, 8'd0, 8'h00, 8'd16, 8'h01, 8'h0F,
                             8'd3, 8'd0, 8'h00, 8'd16, 8'h03, 8'h0F, REJECTED});
    directed_rows.push_back({8'd3, 8'd0, 8'h00, 8'd16, 8'h0F, 8'h04,
                             8'd3, 8'd0, 8'h00, 8'd16, 8'h0F, 8'h0C, REJECTED});
    // all-ones and all-zeros bytes
    directed_rows.push_back({96'hFFFF_FFFF_FFFF_FFFF_FFFF_FFFF, REJECTED});
    directed_rows.push_back({96'h0, REJECTED});
    // OOB: SC needs one flag, legacy needs both
    directed_rows.push_back({8'd0, 8'd1, 8'h08, 8'd12, 8'h0F, 8'h0F,
                             8'd4, 8'd0, 8'h08, 8'd10, 8'h05, 8'h03, BY_MODEL});
    directed_rows.push_back({8'd3, 8'd1, 8'h04, 8'd16, 8'h0F, 8'h0F,
                             8'd3, 8'd0, 8'h04, 8'd16, 8'h0F, 8'h0F, BY_MODEL});
    directed_rows.push_back({8'd2, 8'd1, 8'h05, 8'd9,  8'h0F, 8'h0F,
                             8'd2, 8'd1, 8'h01, 8'd16, 8'h03, 8'h0F, BY_MODEL});
    // passkey variants and IO pairs with no passkey rule
    directed_rows.push_back({8'd2, 8'd0, 8'h04, 8'd16, 8'h0F, 8'h0F,
                             8'd2, 8'd0, 8'h00, 8'd16, 8'h0F, 8'h0F, BY_MODEL});
    directed_rows.push_back({8'd2, 8'd0, 8'h05, 8'd16, 8'h0F, 8'h0F,
                             8'd0, 8'd0, 8'h05, 8'd16, 8'h0F, 8'h0F, BY_MODEL});
    directed_rows.push_back({8'd4, 8'd0, 8'h0C, 8'd16, 8'h0F, 8'h0F,
                             8'd2, 8'd0, 8'h0C, 8'd16, 8'h0F, 8'h0F, BY_MODEL});
    directed_rows.push_back({8'd1, 8'd0, 8'h04, 8'd16, 8'h0F, 8'h0F,
                             8'd1, 8'd0, 8'h04, 8'd16, 8'h0F, 8'h0F, BY_MODEL});
    directed_rows.push_back({8'd3, 8'd0, 8'h0D, 8'd16, 8'h0F, 8'h0F,
                             8'd2, 8'd0, 8'h0D, 8'd16, 8'h0F, 8'h0F, BY_MODEL});
    directed_rows.push_back({8'd2, 8'd0, 8'h0C, 8'd16, 8'h0F, 8'h0F,
                             8'd4, 8'd0, 8'h0C, 8'd16, 8'h0F, 8'h0F, BY_MODEL});

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_request(row.xchg, row.pinned ? row.want : negotiate(row.xchg));
    end
    run_traffic(250);

    // Mask settings, including both extremes; one phase has random masks
    auth_plan[3] = 8'($urandom_range(0, 255));
    dist_plan[3] = 8'($urandom_range(0, 255));
    for (int p = 0; p < NUM_PHASES; p++) begin
      finish_outstanding();
      write_mask(CFG_AUTH_MASK, auth_plan[p]);
      write_mask(CFG_KEYDIST_MASK, dist_plan[p]);
      // receiver backs off while requests keep coming
      if (p == 2) long_hold_req = 1'b1;
      run_traffic(240);
    end
    finish_outstanding();
    repeat (10) @(posedge clk);

    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/smpn_pkg.sv
hdl/smp_pairing_negotiation.sv
sim/tb_smp_pairing_negotiation.sv
